@@ hw/rtl/mbf_pkg.sv @@
// Shared types, register codes and constants for the masked box-mean fill block.
package mbf_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int CFG_WIDTH_RESET  = 640;
  localparam int CFG_HEIGHT_RESET = 480;

  // Window geometry and arithmetic
  localparam int WIN        = 3;
  localparam int PIX_W      = 8;
  localparam int COLSUM_W   = 10;
  localparam int SUM_W      = 12;
  localparam int DIV9_SHIFT = 15;
  localparam logic [SUM_W-1:0] DIV9_MUL = 12'd3641;

  // One window column: three rows plus the mask of the middle row
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic             mid_mask;
    logic [PIX_W-1:0] bot;
  } column_t;

  // Which rows of the window fall inside the frame
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
  } row_keep_t;

  // Per-word control carried down the pipeline
  typedef struct packed {
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } ctl_t;

  // One result word
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } result_t;

  // Clamp a frame size register to 1..maxv
  function automatic int clamp_size(input logic [CFG_DATA_W-1:0] v, input int maxv);
    int r;
    if (v == '0) begin
      r = 1;
    end else if (int'(v) > maxv) begin
      r = maxv;
    end else begin
      r = int'(v);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mbf_line_store.sv @@
// Two chained line memories giving the pixels one and two rows above the newest word.
module mbf_line_store
  import mbf_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [PIX_W-1:0]         wr_pix,
  input  logic                     wr_mask,
  output logic [PIX_W-1:0]         up1_pix,
  output logic                     up1_mask,
  output logic [PIX_W-1:0]         up2_pix
);

  logic [PIX_W:0]   mem_near [DEPTH];
  logic [PIX_W-1:0] mem_far  [DEPTH];
  logic             fwd;

  // A write landing on the column being read in the same cycle
  assign fwd = wr_en && (wr_addr == rd_addr);

  // Write the newest word into the near line, and the word it displaced into the far line
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_near[wr_addr] <= {wr_mask, wr_pix};
      mem_far[wr_addr]  <= up1_pix;
    end
  end

  // Read both lines at the incoming column, forwarding a colliding write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (fwd) begin
        up1_mask <= wr_mask;
        up1_pix  <= wr_pix;
        up2_pix  <= up1_pix;
      end else begin
        {up1_mask, up1_pix} <= mem_near[rd_addr];
        up2_pix             <= mem_far[rd_addr];
      end
    end
  end

endmodule

@@ hw/rtl/mbf_col_cell.sv @@
// One window column cell: holds a column, passes it on, and forms its masked column sum.
module mbf_col_cell
  import mbf_pkg::*;
(
  input  logic                clk,
  input  logic                shift,
  input  column_t             col_in,
  input  row_keep_t           keep,
  input  logic                col_ok,
  output column_t             col_q,
  output logic [COLSUM_W-1:0] col_sum
);

  logic [COLSUM_W-1:0] top_v;
  logic [COLSUM_W-1:0] bot_v;

  // Take the neighbor's column on every accepted word
  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

  // Drop rows and columns outside the frame
  always_comb begin
    top_v = keep.top_ok ? COLSUM_W'(col_q.top) : '0;
    bot_v = keep.bot_ok ? COLSUM_W'(col_q.bot) : '0;
    if (col_ok) begin
      col_sum = top_v + COLSUM_W'(col_q.mid) + bot_v;
    end else begin
      col_sum = '0;
    end
  end

endmodule

@@ hw/rtl/mbf_out_fifo.sv @@
// Two-entry result queue that lets the input side keep going while a result waits.
module mbf_out_fifo
  import mbf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    not_empty,
  output logic    full,
  output result_t head
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = slot[rd_ptr];

  // Store an incoming result
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/masked_box_mean_fill.sv @@
// Top level of the masked 3x3 box-mean fill: counters, line store, cell chain, divide, queue.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  input   | in_valid / in_stall  | cmd, in_pixel, mask_value
//  output  | out_valid / out_stall| out_pixel, out_last
//  config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word is taken per clock while in_stall is low. A result passes through the line memory read,
// window cell shift, column sum and reciprocal multiply by 1/9 before it enters the result queue.
// in_stall rises only when the two-entry result queue is full and out_stall holds it.
// rst is synchronous; it clears the counters, valids and queue and loads the default
// frame size. The line memories need no clearing pass: a frame reads only what it wrote.
module masked_box_mean_fill
  import mbf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic [PIX_W-1:0]      mask_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_pixel,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 2);
  localparam int RST_W = (CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET;
  localparam int RST_H = (CFG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RESET;

  // Frame size and stream position
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [CW-1:0] in_column;
  logic [RW-1:0] in_row;

  logic          accept;
  logic          adv;
  logic          cfg_known;
  logic          fifo_full;

  // Front-end decode of the incoming word
  ctl_t             a_ctl;
  logic             a_res;
  logic             a_zero;
  logic [PIX_W-1:0] a_pix;
  logic             a_mask;
  logic [WW-1:0]    col_inc;

  // Stage B: word read out of the line store
  logic             b_valid;
  logic             b_res;
  ctl_t             b_ctl;
  logic [PIX_W-1:0] b_pix;
  logic             b_mask;
  logic [CW-1:0]    b_col;
  logic [PIX_W-1:0] up1_pix;
  logic             up1_mask;
  logic [PIX_W-1:0] up2_pix;

  // Stage C: window in the cell chain
  logic                c_valid;
  ctl_t                c_ctl;
  column_t             col_new;
  column_t             col_q   [WIN];
  logic [COLSUM_W-1:0] col_sum [WIN];
  logic [WIN-1:0]      cell_ok;
  row_keep_t           c_keep;

  // Stage D: sum ready for the divide
  logic               d_valid;
  logic [SUM_W-1:0]   d_sum;
  logic [PIX_W-1:0]   d_center;
  logic               d_mask;
  logic               d_last;
  logic [2*SUM_W-1:0] d_prod;
  result_t            d_result;
  result_t            fifo_head;

  assign cfg_ready = 1'b1;
  assign adv       = !fifo_full;
  assign in_stall  = fifo_full;
  assign accept    = in_valid && !in_stall;
  assign cfg_known = (cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT);

  // Decode the word: stored value, whether it yields a result, and window edges
  always_comb begin
    a_res = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (in_column != '0));
    if (in_column == '0) begin
      a_ctl.top_ok   = (in_row >= RW'(3));
      a_ctl.bot_ok   = (in_row <= h_eff);
      a_ctl.left_ok  = (w_eff >= WW'(2));
      a_ctl.right_ok = 1'b0;
      a_ctl.last     = (in_row == h_eff + RW'(1));
    end else begin
      a_ctl.top_ok   = (in_row >= RW'(2));
      a_ctl.bot_ok   = (in_row < h_eff);
      a_ctl.left_ok  = (in_column >= CW'(2));
      a_ctl.right_ok = 1'b1;
      a_ctl.last     = 1'b0;
    end
    a_zero  = cmd && (in_row < h_eff);
    a_pix   = a_zero ? '0 : in_pixel;
    a_mask  = !a_zero && (mask_value != '0);
    col_inc = WW'(in_column) + WW'(1);
  end

  // Hold frame size; advance or restart the stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff     <= WW'(RST_W);
      h_eff     <= RW'(RST_H);
      in_column <= '0;
      in_row    <= '0;
    end else if (cfg_valid && cfg_ready && cfg_known) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  w_eff <= WW'(clamp_size(cfg_data, MAX_WIDTH));
        REG_IMAGE_HEIGHT: h_eff <= RW'(clamp_size(cfg_data, MAX_HEIGHT));
        default: ;
      endcase
      in_column <= '0;
      in_row    <= '0;
    end else if (accept) begin
      if (a_ctl.last) begin
        in_column <= '0;
        in_row    <= '0;
      end else if (col_inc >= w_eff) begin
        in_column <= '0;
        in_row    <= in_row + RW'(1);
      end else begin
        in_column <= col_inc[CW-1:0];
      end
    end
  end

  // Stage B registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_res  <= a_res;
      b_ctl  <= a_ctl;
      b_pix  <= a_pix;
      b_mask <= a_mask;
      b_col  <= in_column;
    end
  end

  mbf_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (in_column),
    .wr_en    (adv && b_valid),
    .wr_addr  (b_col),
    .wr_pix   (b_pix),
    .wr_mask  (b_mask),
    .up1_pix  (up1_pix),
    .up1_mask (up1_mask),
    .up2_pix  (up2_pix)
  );

  // Newest column entering the cell chain
  always_comb begin
    col_new.top      = up2_pix;
    col_new.mid      = up1_pix;
    col_new.mid_mask = up1_mask;
    col_new.bot      = b_pix;
  end

  // Stage C control
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid && b_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid) begin
      c_ctl <= b_ctl;
    end
  end

  assign c_keep.top_ok = c_ctl.top_ok;
  assign c_keep.bot_ok = c_ctl.bot_ok;
  assign cell_ok       = {c_ctl.left_ok, 1'b1, c_ctl.right_ok};

  // Chain of column cells: right column first, left column last
  for (genvar k = 0; k < WIN; k++) begin : g_cell
    if (k == 0) begin : g_head
      mbf_col_cell u_cell (
        .clk     (clk),
        .shift   (adv && b_valid),
        .col_in  (col_new),
        .keep    (c_keep),
        .col_ok  (cell_ok[k]),
        .col_q   (col_q[k]),
        .col_sum (col_sum[k])
      );
    end else begin : g_body
      mbf_col_cell u_cell (
        .clk     (clk),
        .shift   (adv && b_valid),
        .col_in  (col_q[k-1]),
        .keep    (c_keep),
        .col_ok  (cell_ok[k]),
        .col_q   (col_q[k]),
        .col_sum (col_sum[k])
      );
    end
  end

  // Stage D: full window sum and centre
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_valid) begin
      d_sum    <= SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);
      d_center <= col_q[1].mid;
      d_mask   <= col_q[1].mid_mask;
      d_last   <= c_ctl.last;
    end
  end

  // Divide by nine with a reciprocal multiply; keep the centre when unmasked
  always_comb begin
    d_prod         = (2*SUM_W)'(d_sum) * (2*SUM_W)'(DIV9_MUL);
    d_result.pixel = d_mask ? d_prod[DIV9_SHIFT +: PIX_W] : d_center;
    d_result.last  = d_last;
  end

  mbf_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && d_valid),
    .push_data (d_result),
    .pop       (out_valid && !out_stall),
    .not_empty (out_valid),
    .full      (fifo_full),
    .head      (fifo_head)
  );

  assign out_pixel = fifo_head.pixel;
  assign out_last  = fifo_head.last;

  // The frame's final word restarts the position
  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && a_ctl.last && !(cfg_valid && cfg_known)) |=> (in_column == '0 && in_row == '0))
    else $error("position not restarted after final word");

  // Column position stays inside the row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    accept |-> (WW'(in_column) < w_eff))
    else $error("column position beyond frame width");

  // Input is held back only while results are queued
  a_stall_queued: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no queued result");

endmodule

@@ verif/tb_masked_box_mean_fill.sv @@
// Self-checking testbench for the masked 3x3 box-mean fill block.
`timescale 1ns / 100ps

module tb_masked_box_mean_fill;
  import mbf_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int HIST_DEPTH   = 2 * MAX_W + 3;
  localparam int IDLE_GAP     = 8;
  localparam int RANDOM_WORDS = 1500;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DIR_ROWS     = 26;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Indexes past the register list; writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_VALUE
  } chk_e;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] mask;
    chk_e             chk;
    logic [PIX_W-1:0] want_pix;
    logic             want_last;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  cmd;
  logic [PIX_W-1:0]      in_pixel;
  logic [PIX_W-1:0]      mask_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_W-1:0]      out_pixel;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: size registers, pixel and mask history, stream position
  logic [CFG_DATA_W-1:0] size_w_reg = CFG_DATA_W'(CFG_WIDTH_RESET);
  logic [CFG_DATA_W-1:0] size_h_reg = CFG_DATA_W'(CFG_HEIGHT_RESET);
  logic [PIX_W-1:0]      hist_pix [HIST_DEPTH];
  bit                    hist_miss [HIST_DEPTH];
  int                    wr_slot = 0;
  int                    col_pos = 0;
  int                    row_pos = 0;
  int                    outs_done = 0;

  result_t fill_queue [$];
  int      mismatch_count = 0;
  int      words_sent = 0;
  int      cycle_count = 0;
  int      burst_left = 0;
  int      hold_left = 0;
  bit      sending = 1'b0;

  // Directed frames, 3x3. First: all 255 with one unmasked pixel, so corners
  // average four values, edges six, the centre nine. Second: flush words among
  // the pixels and pixel words during the drain.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_PIXEL, 8'd255, 8'hFF, CHK_NONE,  8'd0,   1'b0},
    '{CMD_PIXEL, 8'd255, 8'h01, CHK_NONE,  8'd0,   1'b0},
    '{CMD_PIXEL, 8'd255, 8'h80, CHK_NONE,  8'd0,   1'b0},
    '{CMD_PIXEL, 8'd255, 8'h02, CHK_NONE,  8'd0,   1'b0},
    '{CMD_PIXEL, 8'd255, 8'hFF, CHK_VALUE, 8'd113, 1'b0},
    '{CMD_PIXEL, 8'd255, 8'h00, CHK_VALUE, 8'd170, 1'b0},
    '{CMD_PIXEL, 8'd255, 8'h7F, CHK_VALUE, 8'd113, 1'b0},
    '{CMD_PIXEL, 8'd255, 8'h40, CHK_VALUE, 8'd170, 1'b0},
    '{CMD_PIXEL, 8'd255, 8'hFF, CHK_VALUE, 8'd255, 1'b0},
    '{CMD_FLUSH, 8'd0,   8'h00, CHK_VALUE, 8'd255, 1'b0},
    '{CMD_FLUSH, 8'd0,   8'h00, CHK_VALUE, 8'd113, 1'b0},
    '{CMD_FLUSH, 8'd0,   8'h00, CHK_VALUE, 8'd170, 1'b0},
    '{CMD_FLUSH, 8'd0,   8'h00, CHK_VALUE, 8'd113, 1'b1},
    '{CMD_PIXEL, 8'd0,   8'h00, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_FLUSH, 8'hAA,  8'hFF, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_PIXEL, 8'd255, 8'hFF, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_PIXEL, 8'h55,  8'h01, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_PIXEL, 8'd0,   8'hFF, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_PIXEL, 8'd200, 8'h80, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_FLUSH, 8'hFF,  8'hFF, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_PIXEL, 8'd1,   8'h00, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_PIXEL, 8'd254, 8'hFE, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_PIXEL, 8'h99,  8'h33, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_FLUSH, 8'd0,   8'h00, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_PIXEL, 8'hFF,  8'hFF, CHK_MODEL, 8'd0,   1'b0},
    '{CMD_FLUSH, 8'd0,   8'h00, CHK_MODEL, 8'd0,   1'b0}
  };

  masked_box_mean_fill dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int fit_size(input logic [CFG_DATA_W-1:0] v, input int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function void restart_frame();
    col_pos = 0;
    row_pos = 0;
    outs_done = 0;
  endfunction

  function void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_IMAGE_WIDTH) begin
      size_w_reg = data;
      restart_frame();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      size_h_reg = data;
      restart_frame();
    end
  endfunction

  // Store one word in the history and work out the filled pixel it releases, if any
  function void box_fill_step(input logic c, input logic [PIX_W-1:0] p,
                              input logic [PIX_W-1:0] m, output bit made,
                              output result_t res);
    int w, h, total, pos, q, r, c0, rr, cc, back, slot, sum;
    logic [PIX_W-1:0] centre;
    bit ends_frame;
    w = fit_size(size_w_reg, MAX_W);
    h = fit_size(size_h_reg, MAX_H);
    total = w * h;
    pos = row_pos * w + col_pos;
    made = 1'b0;
    res = '0;
    ends_frame = 1'b0;
    centre = '0;
    // a flush inside the frame stands as an unmasked zero pixel
    if (c == CMD_FLUSH && pos < total) begin
      hist_pix[wr_slot] = '0;
      hist_miss[wr_slot] = 1'b0;
    end else begin
      hist_pix[wr_slot] = p;
      hist_miss[wr_slot] = (m != '0);
    end
    if (pos >= w + 1 && outs_done < total) begin
      q = outs_done;
      r = q / w;
      c0 = q % w;
      sum = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = r + dr;
          cc = c0 + dc;
          if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
            back = w + 1 - dr * w - dc;
            slot = (wr_slot + HIST_DEPTH - back) % HIST_DEPTH;
            sum += hist_pix[slot];
            if (dr == 0 && dc == 0) centre = hist_pix[slot];
          end
        end
      end
      slot = (wr_slot + HIST_DEPTH - (w + 1)) % HIST_DEPTH;
      res.pixel = hist_miss[slot] ? PIX_W'(sum / 9) : centre;
      res.last = (q == total - 1);
      ends_frame = res.last;
      outs_done = q + 1;
      made = 1'b1;
    end
    wr_slot = (wr_slot + 1) % HIST_DEPTH;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (ends_frame) restart_frame();
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_mask();
    if ($urandom_range(0, 1) == 0) return '0;
    if ($urandom_range(0, 9) == 0) return '1;
    return PIX_W'($urandom_range(1, 255));
  endfunction

  // Offer one word, hold it through stalls, and book what it should release
  task automatic send_word(input logic c, input logic [PIX_W-1:0] p,
                           input logic [PIX_W-1:0] m, input chk_e chk,
                           input result_t want);
    bit made;
    result_t res;
    in_valid <= 1'b1;
    cmd <= c;
    in_pixel <= p;
    mask_value <= m;
    sending = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    box_fill_step(c, p, m, made, res);
    words_sent++;
    case (chk)
      CHK_MODEL: if (made) fill_queue.push_back(res);
      CHK_VALUE: fill_queue.push_back(want);
      default: ;
    endcase
  endtask

  // Close a burst now and then and leave a random gap
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 2);
        2: gap = $urandom_range(3, 8);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        sending = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Drop valid and wait until every expected word is back and the pipe is empty
  task automatic wait_idle();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    while (fill_queue.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send whole frames plus a partial tail; sometimes pause for a spare register write
  task automatic run_phase(input logic [CFG_DATA_W-1:0] w_raw, input logic [CFG_DATA_W-1:0] h_raw,
                           input int nframes, input int tail_words, input bit set_size);
    int w, npix, flen, total, pause_at, noise_pct;
    logic c;
    logic [CFG_IDX_W-1:0] spare;
    if (set_size) begin
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, w_raw);
      write_reg(REG_IMAGE_HEIGHT, h_raw);
    end
    w = fit_size(size_w_reg, MAX_W);
    npix = w * fit_size(size_h_reg, MAX_H);
    flen = npix + w + 1;
    total = nframes * flen + tail_words;
    noise_pct = ($urandom_range(0, 4) == 0) ? 10 : 0;
    pause_at = -1;
    if (total > 0 && $urandom_range(0, 2) == 0) pause_at = $urandom_range(0, total - 1);
    for (int k = 0; k < total; k++) begin
      if (k == pause_at) begin
        wait_idle();
        spare = ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B;
        write_reg(spare, CFG_DATA_W'($urandom_range(0, 2047)));
      end
      c = ((k % flen) >= npix) ? CMD_FLUSH : CMD_PIXEL;
      if ($urandom_range(0, 99) < noise_pct) c = ~c;
      send_word(c, pick_pixel(), pick_mask(), CHK_MODEL, '0);
      pace();
    end
  endtask

  // Receiver stall pattern: free stretches, stall runs, and choppy spells
  always @(posedge clk) begin
    if (hold_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall <= 1'b0;
          hold_left <= $urandom_range(20, 80);
        end
        1: begin
          out_stall <= 1'b1;
          hold_left <= $urandom_range(1, 10);
        end
        default: begin
          out_stall <= ($urandom_range(0, 1) != 0);
          hold_left <= $urandom_range(0, 3);
        end
      endcase
    end else begin
      hold_left <= hold_left - 1;
    end
  end

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (fill_queue.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word: expected none, actual pixel %0d last %0b",
                 $time, out_pixel, out_last);
      end else begin
        want = fill_queue.pop_front();
        if (out_pixel !== want.pixel) begin
          mismatch_count++;
          $display("%0t: out_pixel mismatch: expected %0d, actual %0d",
                   $time, want.pixel, out_pixel);
        end
        if (out_last !== want.last) begin
          mismatch_count++;
          $display("%0t: out_last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_last);
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    result_t want;
    int random_end;
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_PIXEL;
    in_pixel <= '0;
    mask_value <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_pix[i] = '0;
      hist_miss[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset frame size: enough words to pass one 640-pixel line
    run_phase('0, '0, 0, 650, 1'b0);

    // directed frames on a 3x3 image
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    for (int i = 0; i < DIR_ROWS; i++) begin
      want.pixel = dir_rows[i].want_pix;
      want.last = dir_rows[i].want_last;
      send_word(dir_rows[i].cmd, dir_rows[i].pix, dir_rows[i].mask, dir_rows[i].chk, want);
      pace();
    end

    // size extremes: saturated width over two rows cut short, saturated
    // height on a one-pixel column, zero sizes acting as one
    run_phase(11'd2047, 11'd2, 0, 1065, 1'b1);
    run_phase(11'd1, 11'd2047, 1, 0, 1'b1);
    run_phase(11'd0, 11'd0, 3, 1, 1'b1);
    run_phase(11'd1024, 11'd1, 0, 1100, 1'b1);

    // random small frames
    random_end = words_sent + RANDOM_WORDS;
    while (words_sent < random_end) begin
      run_phase(($urandom_range(0, 9) == 0) ? 11'd0 :
                ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(9, 40)) :
                CFG_DATA_W'($urandom_range(1, 8)),
                ($urandom_range(0, 9) == 0) ? 11'd0 : CFG_DATA_W'($urandom_range(1, 6)),
                $urandom_range(1, 3),
                ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0,
                1'b1);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
